### src/lru_chunk_buffer_cache_unit_macros.svh
// ----------------------------------------------------------------------------
// LRU chunk buffer cache - assertion macros
// Concurrent check helpers; they expand to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef LRU_CHUNK_BUFFER_CACHE_UNIT_MACROS_SVH
`define LRU_CHUNK_BUFFER_CACHE_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define LCB_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lcb check failed");
`define LCB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lcb check failed");
`else
`define LCB_ASSERT_IMP(lbl, ante, cons)
`define LCB_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

### src/lcb_pkg.sv
// ----------------------------------------------------------------------------
// LRU chunk buffer cache - package
// Field widths, command, status and register codes, default parameters.
// ----------------------------------------------------------------------------
package lcb_pkg;

  localparam int unsigned SLOTS_DEF   = 16;
  localparam int unsigned ID_BITS_DEF = 16;

  localparam int unsigned CMD_W        = 2;
  localparam int unsigned CHUNK_NUM_W  = 16;
  localparam int unsigned SLOT_FIELD_W = 4;
  localparam int unsigned ADDR_W       = 48;
  localparam int unsigned STATUS_W     = 2;
  localparam int unsigned BYTES_W      = 21;
  localparam int unsigned TOTAL_W      = 17;
  localparam int unsigned CFG_IDX_W    = 2;
  localparam int unsigned CFG_DATA_W   = 48;

  localparam logic [CMD_W-1:0] CMD_READ    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_WRITE   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd2;

  localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_NOT_BUSY = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_RANGE    = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_FULL     = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_REGION_BASE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHUNK_BYTES = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CHUNK_TOTAL = 2'd2;

endpackage

### src/lcb_ifs.sv
// ----------------------------------------------------------------------------
// LRU chunk buffer cache - channel interfaces
// Command, result and register write channels, valid/ready handshake.
// ----------------------------------------------------------------------------
interface lcb_in_if import lcb_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic [CMD_W-1:0]        command;
  logic [CHUNK_NUM_W-1:0]  chunk_num;
  logic [SLOT_FIELD_W-1:0] slot;

  modport source (output valid, output command, output chunk_num, output slot, input ready);
  modport sink   (input valid, input command, input chunk_num, input slot, output ready);
endinterface

interface lcb_out_if import lcb_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic [SLOT_FIELD_W-1:0] slot_out;
  logic                    was_valid;
  logic [ADDR_W-1:0]       chunk_address;
  logic [STATUS_W-1:0]     status;

  modport source (output valid, output slot_out, output was_valid, output chunk_address,
                  output status, input ready);
  modport sink   (input valid, input slot_out, input was_valid, input chunk_address,
                  input status, output ready);
endinterface

interface lcb_cfg_if import lcb_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### src/lru_chunk_buffer_cache_unit.sv
// ----------------------------------------------------------------------------
// LRU chunk buffer cache unit
// Commands: one word at a time, taken only in idle; the result is written to
//   the output reg before a new one is accepted. The recency scans read the
//   order memory once per cycle.
// Reset: control, busy/valid marks and result valid clear at once, data regs do
//   not; the memories read as reset contents until written (per-entry marks, no sweep).
// ----------------------------------------------------------------------------
`include "lru_chunk_buffer_cache_unit_macros.svh"

module lru_chunk_buffer_cache_unit import lcb_pkg::*; #(
  parameter int unsigned SLOTS   = SLOTS_DEF,
  parameter int unsigned ID_BITS = ID_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  lcb_cfg_if.sink     cfg_i,
  lcb_in_if.sink      in_i,
  lcb_out_if.source   res_o
);

  localparam int unsigned SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CHUNK_W = (ID_BITS < CHUNK_NUM_W) ? ID_BITS : CHUNK_NUM_W;
  localparam int unsigned SXW     = (SLOT_W > SLOT_FIELD_W) ? SLOT_W : SLOT_FIELD_W;
  localparam int unsigned PROD_W  = CHUNK_W + BYTES_W;

  localparam logic [SLOT_W:0]   K_END    = (SLOT_W+1)'(SLOTS);
  localparam logic [SXW:0]      S_LIMIT  = (SXW+1)'(SLOTS);
  localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(SLOTS - 1);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_NEW  = 4'd1;  // newest-first search for the chunk
  localparam logic [3:0] ST_OLD  = 4'd2;  // oldest-first search for a free slot
  localparam logic [3:0] ST_WRC  = 4'd3;
  localparam logic [3:0] ST_REL  = 4'd4;
  localparam logic [3:0] ST_MUL  = 4'd5;
  localparam logic [3:0] ST_ADD  = 4'd6;
  localparam logic [3:0] ST_DONE = 4'd7;

  // configuration
  logic [ADDR_W-1:0]  base_q;
  logic [BYTES_W-1:0] bytes_q;
  logic [TOTAL_W-1:0] total_q;

  // sequencer
  logic [3:0]          state_q, state_d;
  logic [CMD_W-1:0]    cmd_q, cmd_d;
  logic [CHUNK_W-1:0]  id_q, id_d;
  logic [SLOT_W-1:0]   s_q, s_d;
  logic [SLOT_FIELD_W-1:0] sx_q, sx_d;
  logic [SLOT_W:0]     k_q, k_d;
  logic                p1_q, p1_d, p2_q, p2_d;
  logic [SLOT_W-1:0]   c_q, c_d;
  logic [SLOT_W-1:0]   fnd_q, fnd_d;
  logic [SLOT_W-1:0]   carry_q, carry_d;
  logic                was_q, was_d;
  logic [STATUS_W-1:0] stat_q, stat_d;
  logic [PROD_W-1:0]   prod_q, prod_d;
  logic [ADDR_W-1:0]   addr_q, addr_d;

  logic [SLOTS-1:0] busy_q, busy_d;
  logic [SLOTS-1:0] valid_q, valid_d;
  logic [SLOTS-1:0] ord_init_q, ord_init_d;
  logic [SLOTS-1:0] chk_wr_q, chk_wr_d;

  // memories
  logic              ord_we, chk_we;
  logic [SLOT_W-1:0] ord_waddr, ord_wdata, ord_raddr, ord_raddr_q, ord_rdata, ord_val;
  logic [SLOT_W-1:0] chk_waddr, chk_raddr, chk_raddr_q;
  logic [CHUNK_W-1:0] chk_wdata, chk_rdata, chk_val;

  // output register
  logic                    res_v_q, res_v_d;
  logic [SLOT_FIELD_W-1:0] res_slot_q, res_slot_d;
  logic                    res_was_q, res_was_d;
  logic [ADDR_W-1:0]       res_addr_q, res_addr_d;
  logic [STATUS_W-1:0]     res_stat_q, res_stat_d;

  logic              in_acc;
  logic [SXW-1:0]    in_sx;
  logic [SLOT_W-1:0] in_sidx;
  logic              in_srng;
  logic [CHUNK_W-1:0] in_id;
  logic [SXW-1:0]    fnd_x;
  logic              hit;
  logic              load_res;

  lcb_ram #(.WIDTH(SLOT_W), .DEPTH(SLOTS)) u_order_ram (
    .clk_i   (clk_i),
    .we_i    (ord_we),
    .waddr_i (ord_waddr),
    .wdata_i (ord_wdata),
    .raddr_i (ord_raddr),
    .rdata_o (ord_rdata)
  );

  lcb_ram #(.WIDTH(CHUNK_W), .DEPTH(SLOTS)) u_chunk_ram (
    .clk_i   (clk_i),
    .we_i    (chk_we),
    .waddr_i (chk_waddr),
    .wdata_i (chk_wdata),
    .raddr_i (chk_raddr),
    .rdata_o (chk_rdata)
  );

  // unwritten entries read as their reset contents
  assign ord_val = ord_init_q[ord_raddr_q] ? ord_rdata : (LAST_IDX - ord_raddr_q);
  assign chk_val = chk_wr_q[chk_raddr_q] ? chk_rdata : '0;

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign in_sx      = SXW'(in_i.slot);
  assign in_sidx    = in_sx[SLOT_W-1:0];
  assign in_srng    = {1'b0, in_sx} < S_LIMIT;
  assign in_id      = in_i.chunk_num[CHUNK_W-1:0];
  assign fnd_x      = SXW'(fnd_q);

  assign hit = p2_q && (chk_val == id_q) && !busy_q[c_q];

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q  <= '0;
      bytes_q <= '0;
      total_q <= '0;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_REGION_BASE: base_q  <= cfg_i.data;
        CFG_CHUNK_BYTES: bytes_q <= cfg_i.data[BYTES_W-1:0];
        CFG_CHUNK_TOTAL: total_q <= cfg_i.data[TOTAL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_d      = cmd_q;
    id_d       = id_q;
    s_d        = s_q;
    sx_d       = sx_q;
    k_d        = k_q;
    p1_d       = 1'b0;
    p2_d       = 1'b0;
    c_d        = c_q;
    fnd_d      = fnd_q;
    carry_d    = carry_q;
    was_d      = was_q;
    stat_d     = stat_q;
    prod_d     = prod_q;
    addr_d     = addr_q;
    busy_d     = busy_q;
    valid_d    = valid_q;
    ord_init_d = ord_init_q;
    chk_wr_d   = chk_wr_q;
    ord_we     = 1'b0;
    ord_waddr  = '0;
    ord_wdata  = '0;
    ord_raddr  = '0;
    chk_we     = 1'b0;
    chk_waddr  = '0;
    chk_wdata  = '0;
    chk_raddr  = '0;
    load_res   = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          cmd_d  = in_i.command;
          id_d   = in_id;
          s_d    = in_sidx;
          sx_d   = in_i.slot;
          was_d  = 1'b0;
          stat_d = STAT_OK;
          addr_d = '0;
          fnd_d  = '0;
          state_d = ST_DONE;
          case (in_i.command)
            CMD_READ: begin
              if (TOTAL_W'(in_id) >= total_q) begin
                stat_d = STAT_RANGE;
              end else begin
                ord_raddr = '0;
                k_d       = (SLOT_W+1)'(1);
                p1_d      = 1'b1;
                state_d   = ST_NEW;
              end
            end
            CMD_WRITE, CMD_RELEASE: begin
              if (!in_srng || !busy_q[in_sidx]) begin
                stat_d = STAT_NOT_BUSY;
              end else if (in_i.command == CMD_WRITE) begin
                chk_raddr = in_sidx;
                state_d   = ST_WRC;
              end else begin
                ord_raddr = '0;
                carry_d   = in_sidx;
                state_d   = ST_REL;
              end
            end
            default: sx_d = '0;
          endcase
        end
      end

      ST_NEW: begin
        if (hit) begin
          fnd_d         = c_q;
          was_d         = valid_q[c_q];
          busy_d[c_q]   = 1'b1;
          valid_d[c_q]  = 1'b1;
          state_d       = ST_MUL;
        end else if (!p1_q && (k_q == K_END)) begin
          // newest-first search exhausted: start from the oldest end
          ord_raddr = LAST_IDX;
          k_d       = K_END - (SLOT_W+1)'(1);
          p1_d      = 1'b1;
          state_d   = ST_OLD;
        end else begin
          // three-stage pipe: order read, chunk read, compare
          p2_d = p1_q;
          if (p1_q) begin
            chk_raddr = ord_val;
            c_d       = ord_val;
          end
          if (k_q < K_END) begin
            ord_raddr = k_q[SLOT_W-1:0];
            k_d       = k_q + (SLOT_W+1)'(1);
            p1_d      = 1'b1;
          end
        end
      end

      ST_OLD: begin
        if (p1_q && !busy_q[ord_val]) begin
          fnd_d              = ord_val;
          chk_we             = 1'b1;
          chk_waddr          = ord_val;
          chk_wdata          = id_q;
          chk_wr_d[ord_val]  = 1'b1;
          busy_d[ord_val]    = 1'b1;
          valid_d[ord_val]   = 1'b1;
          was_d              = 1'b0;
          state_d            = ST_MUL;
        end else if (k_q == '0) begin
          stat_d  = STAT_FULL;
          fnd_d   = '0;
          state_d = ST_DONE;
        end else begin
          ord_raddr = SLOT_W'(k_q - (SLOT_W+1)'(1));
          k_d       = k_q - (SLOT_W+1)'(1);
          p1_d      = 1'b1;
        end
      end

      ST_WRC: begin
        if (TOTAL_W'(chk_val) >= total_q) begin
          stat_d  = STAT_RANGE;
          state_d = ST_DONE;
        end else begin
          valid_d[s_q] = 1'b1;
          id_d         = chk_val;
          state_d      = ST_MUL;
        end
      end

      ST_REL: begin
        // shift each entry down one place until the released slot or the last entry is met
        ord_we                  = 1'b1;
        ord_waddr               = ord_raddr_q;
        ord_wdata               = carry_q;
        ord_init_d[ord_raddr_q] = 1'b1;
        if ((ord_val == s_q) || (ord_raddr_q == LAST_IDX)) begin
          busy_d[s_q] = 1'b0;
          state_d     = ST_DONE;
        end else begin
          carry_d   = ord_val;
          ord_raddr = ord_raddr_q + SLOT_W'(1);
        end
      end

      ST_MUL: begin
        prod_d  = PROD_W'(id_q) * PROD_W'(bytes_q);
        state_d = ST_ADD;
      end

      ST_ADD: begin
        addr_d  = base_q + ADDR_W'(prod_q);
        state_d = ST_DONE;
      end

      ST_DONE: begin
        if (!res_v_q || res_o.ready) begin
          load_res = 1'b1;
          state_d  = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    res_v_d    = res_v_q && !res_o.ready;
    res_slot_d = res_slot_q;
    res_was_d  = res_was_q;
    res_addr_d = res_addr_q;
    res_stat_d = res_stat_q;
    if (load_res) begin
      res_v_d    = 1'b1;
      res_was_d  = was_q;
      res_addr_d = addr_q;
      res_stat_d = stat_q;
      case (cmd_q)
        CMD_READ:                res_slot_d = fnd_x[SLOT_FIELD_W-1:0];
        CMD_WRITE, CMD_RELEASE:  res_slot_d = sx_q;
        default:                 res_slot_d = '0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      k_q         <= '0;
      p1_q        <= 1'b0;
      p2_q        <= 1'b0;
      busy_q      <= '0;
      valid_q     <= '0;
      ord_init_q  <= '0;
      chk_wr_q    <= '0;
      ord_raddr_q <= '0;
      chk_raddr_q <= '0;
      res_v_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      k_q         <= k_d;
      p1_q        <= p1_d;
      p2_q        <= p2_d;
      busy_q      <= busy_d;
      valid_q     <= valid_d;
      ord_init_q  <= ord_init_d;
      chk_wr_q    <= chk_wr_d;
      ord_raddr_q <= ord_raddr;
      chk_raddr_q <= chk_raddr;
      res_v_q     <= res_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    id_q       <= id_d;
    s_q        <= s_d;
    sx_q       <= sx_d;
    c_q        <= c_d;
    fnd_q      <= fnd_d;
    carry_q    <= carry_d;
    was_q      <= was_d;
    stat_q     <= stat_d;
    prod_q     <= prod_d;
    addr_q     <= addr_d;
    res_slot_q <= res_slot_d;
    res_was_q  <= res_was_d;
    res_addr_q <= res_addr_d;
    res_stat_q <= res_stat_d;
  end

  assign res_o.valid         = res_v_q;
  assign res_o.slot_out      = res_slot_q;
  assign res_o.was_valid     = res_was_q;
  assign res_o.chunk_address = res_addr_q;
  assign res_o.status        = res_stat_q;

  `LCB_ASSERT_NEXT(a_leave_idle, in_acc, state_q != ST_IDLE)
  `LCB_ASSERT_IMP(a_read_claims, (state_q == ST_DONE) && (cmd_q == CMD_READ) && (stat_q == STAT_OK), busy_q[fnd_q])
  `LCB_ASSERT_IMP(a_release_frees, (state_q == ST_DONE) && (cmd_q == CMD_RELEASE) && (stat_q == STAT_OK), !busy_q[s_q])

endmodule

### src/lcb_ram.sv
// ----------------------------------------------------------------------------
// LRU chunk buffer cache - generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module lcb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
